// File: src/cltq_pkg.sv
`default_nettype none
package cltq_pkg;

   // Table geometry and field widths
   localparam int MAX_TASKS = 16;
   localparam int ID_W = 4;
   localparam int CNT_W = 5;
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_TASKS);

   // Request modes
   localparam logic [1:0] MODE_PUSH_BACK = 2'd0;
   localparam logic [1:0] MODE_INSERT = 2'd1;
   localparam logic [1:0] MODE_POP_FRONT = 2'd2;
   localparam logic [1:0] MODE_REMOVE = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      logic [ID_W-1:0] task_id;
      logic [ID_W-1:0] anchor_id;
      logic anchor_given;
   } cltq_req_type;

   typedef struct packed {
      logic [ID_W-1:0] popped_task;
      logic popped_valid;
      logic list_empty;
      logic [CNT_W-1:0] entry_count;
   } cltq_rsp_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LINK_A,
      ST_LINK_B,
      ST_DONE
   } cltq_state_type;

   // Link operation chosen at accept time
   typedef enum logic [2:0] {
      OP_NONE,
      OP_FIRST,
      OP_LINK,
      OP_UNLINK,
      OP_CLEAR
   } cltq_op_type;

   // True when a task id names an entry of the link tables
   function automatic logic id_ok(input logic [ID_W-1:0] id);
      logic [CNT_W-1:0] wide;
      wide = {{(CNT_W-ID_W){1'b0}}, id};
      return wide < CNT_MAX;
   endfunction

endpackage
`default_nettype wire

// File: src/circular_linked_task_queue_top.sv
// Circular doubly linked task queue. A request is taken when start is high
// and busy is low; busy then stays high until its single result has been
// shown. The result is on rsp_data for exactly one cycle with rsp_valid high
// and cannot be held off, so the receiver must take it in that cycle.
// A link-in to a non-empty queue steps through ST_FETCH, ST_LINK_A,
// ST_LINK_B and ST_DONE; placing the first task or unlinking skips
// ST_LINK_B, and an ignored request or emptying a one-task queue goes from
// ST_FETCH to ST_DONE. The result shows in ST_DONE. The single write port
// of each link table sets the path: a link-in needs four entry writes, two
// per table, in ST_LINK_A and ST_LINK_B after registered reads in ST_FETCH.
`default_nettype none
module circular_linked_task_queue_top (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input wire cltq_pkg::cltq_req_type req_data,
   output logic rsp_valid,
   output cltq_pkg::cltq_rsp_type rsp_data
);
   import cltq_pkg::*;

   // Link tables
   logic [ID_W-1:0] next_mem [MAX_TASKS];
   logic [ID_W-1:0] prev_mem [MAX_TASKS];

   cltq_state_type state_ff, state_in;
   logic [ID_W-1:0] head_ff, head_in;
   logic [CNT_W-1:0] count_ff, count_in;

   cltq_op_type op_ff, op_in;
   logic [ID_W-1:0] task_ff, task_in;
   logic [ID_W-1:0] anchor_ff, anchor_in;
   logic set_head_ff, set_head_in;
   logic [ID_W-1:0] popped_ff, popped_in;
   logic popped_ok_ff, popped_ok_in;

   logic [ID_W-1:0] nxt_rd_ff, prv_rd_ff;

   logic accept, commit, rd_en;
   logic nxt_we, prv_we;
   logic [ID_W-1:0] nxt_wa, nxt_wd, prv_wa, prv_wd;
   logic [ID_W-1:0] nxt_ra, prv_ra;
   logic use_anchor;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);

   // Decode the request against the current head and count
   always_comb begin
      op_in = op_ff;
      task_in = task_ff;
      anchor_in = anchor_ff;
      set_head_in = set_head_ff;
      popped_in = popped_ff;
      popped_ok_in = popped_ok_ff;
      use_anchor = (req_data.mode == MODE_INSERT) && req_data.anchor_given &&
                   (count_ff != '0);
      if (accept) begin
         op_in = OP_NONE;
         task_in = req_data.task_id;
         anchor_in = head_ff;
         set_head_in = 1'b0;
         popped_in = '0;
         popped_ok_in = 1'b0;
         unique case (req_data.mode)
            MODE_PUSH_BACK, MODE_INSERT: begin
               if (id_ok(req_data.task_id) && (count_ff < CNT_MAX) &&
                   (!use_anchor || id_ok(req_data.anchor_id))) begin
                  if (use_anchor) begin
                     op_in = OP_LINK;
                     anchor_in = req_data.anchor_id;
                     set_head_in = (head_ff == req_data.anchor_id);
                  end else if (count_ff == '0) begin
                     op_in = OP_FIRST;
                  end else begin
                     op_in = OP_LINK;
                  end
               end
            end
            MODE_POP_FRONT: begin
               if (count_ff != '0) begin
                  task_in = head_ff;
                  popped_in = head_ff;
                  popped_ok_in = 1'b1;
                  op_in = (count_ff == CNT_W'(1)) ? OP_CLEAR : OP_UNLINK;
               end
            end
            MODE_REMOVE: begin
               if (id_ok(req_data.task_id) && (count_ff != '0)) begin
                  op_in = (count_ff == CNT_W'(1)) ? OP_CLEAR : OP_UNLINK;
               end
            end
            default: op_in = OP_NONE;
         endcase
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (start) state_in = ST_FETCH;
         ST_FETCH: begin
            if (op_ff == OP_NONE || op_ff == OP_CLEAR) state_in = ST_DONE;
            else state_in = ST_LINK_A;
         end
         ST_LINK_A: state_in = (op_ff == OP_LINK) ? ST_LINK_B : ST_DONE;
         ST_LINK_B: state_in = ST_DONE;
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Table port control per state
   always_comb begin
      rd_en = 1'b0;
      nxt_ra = task_ff;
      prv_ra = (op_ff == OP_LINK) ? anchor_ff : task_ff;
      nxt_we = 1'b0;
      prv_we = 1'b0;
      nxt_wa = task_ff;
      nxt_wd = task_ff;
      prv_wa = task_ff;
      prv_wd = task_ff;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: ;
         ST_FETCH: rd_en = 1'b1;
         ST_LINK_A: begin
            unique case (op_ff)
               OP_FIRST: begin
                  nxt_we = 1'b1;
                  prv_we = 1'b1;
               end
               OP_LINK: begin
                  nxt_we = 1'b1;
                  nxt_wd = anchor_ff;
                  prv_we = 1'b1;
                  prv_wd = prv_rd_ff;
               end
               OP_UNLINK: begin
                  nxt_we = 1'b1;
                  nxt_wa = prv_rd_ff;
                  nxt_wd = nxt_rd_ff;
                  prv_we = 1'b1;
                  prv_wa = nxt_rd_ff;
                  prv_wd = prv_rd_ff;
               end
               default: ;
            endcase
         end
         ST_LINK_B: begin
            nxt_we = 1'b1;
            nxt_wa = prv_rd_ff;
            prv_we = 1'b1;
            prv_wa = anchor_ff;
         end
         ST_DONE: rsp_valid = 1'b1;
         default: ;
      endcase
   end

   // Commit head and count on the way into the result cycle
   assign commit = (state_in == ST_DONE) && (state_ff != ST_DONE);

   always_comb begin
      head_in = head_ff;
      count_in = count_ff;
      if (commit) begin
         case (op_ff)
            OP_FIRST: begin
               head_in = task_ff;
               count_in = CNT_W'(1);
            end
            OP_LINK: begin
               count_in = count_ff + CNT_W'(1);
               if (set_head_ff) head_in = task_ff;
            end
            OP_UNLINK: begin
               count_in = count_ff - CNT_W'(1);
               if (head_ff == task_ff) head_in = nxt_rd_ff;
            end
            OP_CLEAR: begin
               head_in = '0;
               count_in = '0;
            end
            default: ;
         endcase
      end
   end

   assign rsp_data.popped_task = popped_ff;
   assign rsp_data.popped_valid = popped_ok_ff;
   assign rsp_data.list_empty = (count_ff == '0);
   assign rsp_data.entry_count = count_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff <= '0;
         count_ff <= '0;
         op_ff <= OP_NONE;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         count_ff <= count_in;
         op_ff <= op_in;
      end
   end

   // Request payload holding
   always_ff @(posedge clock) begin
      task_ff <= task_in;
      anchor_ff <= anchor_in;
      set_head_ff <= set_head_in;
      popped_ff <= popped_in;
      popped_ok_ff <= popped_ok_in;
   end

   // Next-link table: one write, one registered read
   always_ff @(posedge clock) begin
      if (nxt_we) next_mem[nxt_wa] <= nxt_wd;
      if (rd_en) nxt_rd_ff <= next_mem[nxt_ra];
   end

   // Prev-link table: one write, one registered read
   always_ff @(posedge clock) begin
      if (prv_we) prev_mem[prv_wa] <= prv_wd;
      if (rd_en) prv_rd_ff <= prev_mem[prv_ra];
   end

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_MAX)
      else $error("task count above table size");

   a_empty_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == '0))
      else $error("empty queue with nonzero head");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted beat did not raise busy");

   a_rsp_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("busy held after result beat");

endmodule
`default_nettype wire
